/* rtl/core/bre_pkg.sv */
// Shared types and constants for the binary range encoder core.
package bre_pkg;

    localparam int unsigned BOUND_W     = 32;
    localparam int unsigned PROB_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned RUN_CNT_W   = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned S_TDATA_W   = 24;

    localparam logic [BOUND_W-1:0] LOW_RESET  = 32'h0000_0000;
    localparam logic [BOUND_W-1:0] HIGH_RESET = 32'hffff_ffff;

    typedef enum logic {
        FUNC_ENCODE = 1'b0,
        FUNC_FLUSH  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_MUL,
        FE_UPD
    } t_fe_state;

    typedef struct packed {
        logic [BOUND_W-1:0]   word;
        logic [RUN_CNT_W-1:0] count;
        logic                 flush;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/core/bre_front.sv */
// Front part: takes items, updates the coding interval and emits byte runs.
module bre_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bre_pkg::t_func              i_func,
    input  logic [bre_pkg::PROB_W-1:0]  i_prob_one,
    input  logic                        i_bit_value,
    output logic                        o_push,
    output bre_pkg::t_run               o_run,
    input  bre_pkg::t_q_status          i_q_status
);

    bre_pkg::t_fe_state            r_state, n_state;
    logic [bre_pkg::BOUND_W-1:0]   r_low, n_low;
    logic [bre_pkg::BOUND_W-1:0]   r_high, n_high;
    logic [bre_pkg::BOUND_W-1:0]   r_width, n_width;
    logic [bre_pkg::BOUND_W-1:0]   r_prod_hi, n_prod_hi;
    logic [bre_pkg::PROB_W-1:0]    r_prod_lo, n_prod_lo;
    logic [bre_pkg::PROB_W-1:0]    r_prob, n_prob;
    logic                          r_bit, n_bit;
    bre_pkg::t_func                r_func, n_func;

    logic [bre_pkg::BOUND_W-1:0]   w_prod_lo_full;
    logic [bre_pkg::BOUND_W-1:0]   w_mid;
    logic [bre_pkg::BOUND_W-1:0]   w_lo;
    logic [bre_pkg::BOUND_W-1:0]   w_hi;
    logic [bre_pkg::RUN_CNT_W-1:0] w_count;
    logic [3:0]                    w_agree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bre_pkg::FE_IDLE;
            r_low   <= bre_pkg::LOW_RESET;
            r_high  <= bre_pkg::HIGH_RESET;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width   <= n_width;
        r_prod_hi <= n_prod_hi;
        r_prod_lo <= n_prod_lo;
        r_prob    <= n_prob;
        r_bit     <= n_bit;
        r_func    <= n_func;
    end

    assign w_prod_lo_full = {16'h0000, r_width[15:0]} * {16'h0000, r_prob};
    assign w_mid = r_low + r_prod_hi + {16'h0000, r_prod_lo};
    assign w_lo  = r_bit ? r_low : w_mid + 32'd1;
    assign w_hi  = r_bit ? w_mid : r_high;

    assign w_agree[3] = (w_lo[31:24] == w_hi[31:24]);
    assign w_agree[2] = (w_lo[23:16] == w_hi[23:16]);
    assign w_agree[1] = (w_lo[15:8]  == w_hi[15:8]);
    assign w_agree[0] = (w_lo[7:0]   == w_hi[7:0]);

    always_comb begin
        if (!w_agree[3]) begin
            w_count = 3'd0;
        end else if (!w_agree[2]) begin
            w_count = 3'd1;
        end else if (!w_agree[1]) begin
            w_count = 3'd2;
        end else if (!w_agree[0]) begin
            w_count = 3'd3;
        end else begin
            w_count = 3'd4;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_low     = r_low;
        n_high    = r_high;
        n_width   = r_width;
        n_prod_hi = r_prod_hi;
        n_prod_lo = r_prod_lo;
        n_prob    = r_prob;
        n_bit     = r_bit;
        n_func    = r_func;
        o_ready   = 1'b0;
        o_push    = 1'b0;
        o_run     = '{word: w_hi, count: w_count, flush: 1'b0};
        case (r_state)
            bre_pkg::FE_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_func  = i_func;
                    n_prob  = i_prob_one;
                    n_bit   = i_bit_value;
                    n_width = r_high - r_low;
                    n_state = (i_func == bre_pkg::FUNC_FLUSH) ? bre_pkg::FE_UPD
                                                              : bre_pkg::FE_MUL;
                end
            end
            bre_pkg::FE_MUL: begin
                n_prod_hi = {16'h0000, r_width[31:16]} * {16'h0000, r_prob};
                n_prod_lo = w_prod_lo_full[31:16];
                n_state   = bre_pkg::FE_UPD;
            end
            bre_pkg::FE_UPD: begin
                if (r_func == bre_pkg::FUNC_FLUSH) begin
                    o_run = '{word: r_high, count: 3'd1, flush: 1'b1};
                    if (!i_q_status.full) begin
                        o_push  = 1'b1;
                        n_low   = bre_pkg::LOW_RESET;
                        n_high  = bre_pkg::HIGH_RESET;
                        n_state = bre_pkg::FE_IDLE;
                    end
                end else if (w_count == 3'd0 || !i_q_status.full) begin
                    o_push  = (w_count != 3'd0);
                    n_state = bre_pkg::FE_IDLE;
                    case (w_count)
                        3'd0: begin
                            n_low  = w_lo;
                            n_high = w_hi;
                        end
                        3'd1: begin
                            n_low  = {w_lo[23:0], 8'h00};
                            n_high = {w_hi[23:0], 8'hff};
                        end
                        3'd2: begin
                            n_low  = {w_lo[15:0], 16'h0000};
                            n_high = {w_hi[15:0], 16'hffff};
                        end
                        3'd3: begin
                            n_low  = {w_lo[7:0], 24'h000000};
                            n_high = {w_hi[7:0], 24'hffffff};
                        end
                        default: begin
                            n_low  = bre_pkg::LOW_RESET;
                            n_high = bre_pkg::HIGH_RESET;
                        end
                    endcase
                end
            end
            default: begin
                n_state = bre_pkg::FE_IDLE;
            end
        endcase
    end

    a_top_bytes_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bre_pkg::FE_IDLE |-> r_low[31:24] != r_high[31:24])
        else $error("Bounds agree in their top byte between transactions.");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bre_pkg::FE_IDLE |-> r_low <= r_high)
        else $error("Low bound exceeds high bound.");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_run.count != 3'd0 && !i_q_status.full)
        else $error("Empty run pushed or push into a full queue.");

endmodule

/* rtl/core/bre_queue.sv */
// Short queue of byte runs between the front and back parts.
module bre_queue #(
    parameter int unsigned DEPTH = bre_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bre_pkg::t_run      i_run,
    input  logic               i_pop,
    output bre_pkg::t_run      o_run,
    output bre_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bre_pkg::t_run    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_run          = r_mem[r_rd_ptr];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("Queue fill count exceeds its depth.");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("Queue fill count missed a push.");

endmodule

/* rtl/core/bre_back.sv */
// Back part: splits byte runs into single output bytes behind an output register.
module bre_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bre_pkg::t_run              i_run,
    input  bre_pkg::t_q_status         i_q_status,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bre_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_last,
    output logic                       o_end
);

    logic [bre_pkg::BOUND_W-1:0]   r_word, n_word;
    logic [bre_pkg::RUN_CNT_W-1:0] r_left, n_left;
    logic                          r_flush, n_flush;
    logic                          r_valid, n_valid;
    logic [bre_pkg::BYTE_W-1:0]    r_byte, n_byte;
    logic                          r_last, n_last;
    logic                          r_end, n_end;

    always_comb begin
        n_word  = r_word;
        n_left  = r_left;
        n_flush = r_flush;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_end   = r_end;
        o_pop   = 1'b0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (r_left == '0) begin
            if (!i_q_status.empty) begin
                o_pop   = 1'b1;
                n_word  = i_run.word;
                n_left  = i_run.count;
                n_flush = i_run.flush;
            end
        end else if (!r_valid || i_ready) begin
            n_valid = 1'b1;
            n_byte  = r_word[31:24];
            n_last  = (r_left == 3'd1);
            n_end   = (r_left == 3'd1) && r_flush;
            n_word  = {r_word[23:0], 8'h00};
            n_left  = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_flush <= n_flush;
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_end   <= n_end;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_end   = r_end;

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'd4)
        else $error("Run length out of range.");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_end |-> r_last)
        else $error("Stream end without last byte of run.");

endmodule

/* rtl/core/binary_range_encoder_core.sv */
// Top level of the carryless binary range encoder core.
//
// Channel  Dir  Handshake                 Content
// s        in   i_s_tvalid / o_s_tready   tdata: prob_one, bit_value; tuser: func
// m        out  o_m_tvalid / i_m_tready   tdata: out_byte; tlast: last_in_run;
//                                         tuser: stream_end
//
// An encode transaction passes through capture, multiply and update in the front part, and a
// flush skips the multiply; both 16x16 products of the split are registered before the add.
// The back part pops a run, then emits one byte per cycle while i_m_tready is high.
// Reset is synchronous and active low; the bounds return to 0 and all ones.
// A full queue stalls a front update that must push; the back stalls only on i_m_tready.
module binary_range_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = bre_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [15:0] prob_one, [16] bit_value, [23:17] zero
    input  logic [bre_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] func
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] out_byte
    output logic [bre_pkg::BYTE_W-1:0]      o_m_tdata,
    output logic                            o_m_tlast,
    // [0] stream_end
    output logic                            o_m_tuser
);

    logic               w_push;
    logic               w_pop;
    bre_pkg::t_run      w_run_in;
    bre_pkg::t_run      w_run_out;
    bre_pkg::t_q_status w_q_status;
    bre_pkg::t_func     w_func;

    assign w_func = bre_pkg::t_func'(i_s_tuser);

    bre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_func      (w_func),
        .i_prob_one  (i_s_tdata[15:0]),
        .i_bit_value (i_s_tdata[16]),
        .o_push      (w_push),
        .o_run       (w_run_in),
        .i_q_status  (w_q_status)
    );

    bre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_run    (w_run_in),
        .i_pop    (w_pop),
        .o_run    (w_run_out),
        .o_status (w_q_status)
    );

    bre_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run      (w_run_out),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_last     (o_m_tlast),
        .o_end      (o_m_tuser)
    );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the binary range encoder core with a built-in bound predictor.
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_SLACK = 20;

    typedef struct packed {
        logic [bre_pkg::BYTE_W-1:0] out_byte;
        logic                       last_in_run;
        logic                       stream_end;
    } t_coded_byte;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [bre_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic                          i_s_tuser = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [bre_pkg::BYTE_W-1:0]    o_m_tdata;
    logic                          o_m_tlast;
    logic                          o_m_tuser;

    logic [bre_pkg::BOUND_W-1:0] model_low;
    logic [bre_pkg::BOUND_W-1:0] model_high;
    t_coded_byte                 expected_bytes[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_request = 0;
    int hold_left = 0;

    binary_range_encoder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Splits the interval, shifts out agreeing top bytes; a flush sends the top high byte.
    function automatic void predict_coded_bytes(bre_pkg::t_func func,
                                                logic [bre_pkg::PROB_W-1:0] prob,
                                                logic sym);
        logic [bre_pkg::BOUND_W-1:0] span;
        logic [bre_pkg::BOUND_W-1:0] hi_part;
        logic [bre_pkg::BOUND_W-1:0] lo_part;
        logic [bre_pkg::BOUND_W-1:0] cut_point;
        t_coded_byte                 coded;
        int                          shifted;
        shifted = 0;
        if (func == bre_pkg::FUNC_FLUSH) begin
            coded.out_byte = model_high[31:24];
            coded.last_in_run = 1'b1;
            coded.stream_end = 1'b1;
            expected_bytes.insert(expected_bytes.size(), coded);
            model_low = bre_pkg::LOW_RESET;
            model_high = bre_pkg::HIGH_RESET;
            return;
        end
        span = model_high - model_low;
        hi_part = {16'b0, span[31:16]} * {16'b0, prob};
        lo_part = {16'b0, span[15:0]} * {16'b0, prob};
        cut_point = model_low + hi_part + (lo_part >> 16);
        if (sym) begin
            model_high = cut_point;
        end else begin
            model_low = cut_point + 32'd1;
        end
        while (shifted < 4 && model_low[31:24] == model_high[31:24]) begin
            coded.out_byte = model_high[31:24];
            coded.last_in_run = 1'b0;
            coded.stream_end = 1'b0;
            expected_bytes.insert(expected_bytes.size(), coded);
            model_low = model_low << 8;
            model_high = {model_high[23:0], 8'hff};
            shifted++;
        end
        if (shifted > 0) begin
            expected_bytes[expected_bytes.size() - 1].last_in_run = 1'b1;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    always @(negedge i_clk) begin
        if (stall_request > 0) begin
            hold_left = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_coded_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected byte", o_m_tdata, 0);
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_tdata !== want.out_byte) begin
                    report_mismatch("out_byte", o_m_tdata, want.out_byte);
                end
                if (o_m_tlast !== want.last_in_run) begin
                    report_mismatch("last_in_run", o_m_tlast, want.last_in_run);
                end
                if (o_m_tuser !== want.stream_end) begin
                    report_mismatch("stream_end", o_m_tuser, want.stream_end);
                end
            end
        end
    end

    // Called and returning at a falling edge; valid stays high for a following item.
    task automatic send_item(bre_pkg::t_func func, logic [bre_pkg::PROB_W-1:0] prob,
                             logic sym);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'b0, sym, prob};
        i_s_tuser <= func;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        predict_coded_bytes(func, prob, sym);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        bre_pkg::t_func             func;
        logic [bre_pkg::PROB_W-1:0] prob;
        logic                       sym;
        func = ($urandom_range(99) < 6) ? bre_pkg::FUNC_FLUSH : bre_pkg::FUNC_ENCODE;
        case ($urandom_range(3))
            1: begin
                prob = 16'($urandom_range(255));
            end
            2: begin
                prob = 16'(32'h0000_ffff - $urandom_range(255));
            end
            default: begin
                prob = 16'($urandom_range(65535));
            end
        endcase
        if ($urandom_range(3) == 0) begin
            sym = 1'($urandom_range(1));
        end else begin
            sym = ($urandom_range(65535) < prob);
        end
        send_item(func, prob, sym);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(bre_pkg::FUNC_FLUSH, 16'h0000, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0000, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0000, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'hffff, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'hffff, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0001, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0001, 1'b0);
        send_item(bre_pkg::FUNC_FLUSH, 16'hffff, 1'b1);
        send_item(bre_pkg::FUNC_FLUSH, 16'h0000, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'h8000, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'h8000, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'h5555, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'haaaa, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0000, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0000, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'hfffe, 1'b0);
        send_item(bre_pkg::FUNC_ENCODE, 16'h7fff, 1'b1);
        send_item(bre_pkg::FUNC_FLUSH, 16'h1234, 1'b1);
        send_item(bre_pkg::FUNC_ENCODE, 16'h0000, 1'b0);
        send_item(bre_pkg::FUNC_FLUSH, 16'h0000, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_random_item();
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_request = 300;
        repeat (4) send_item(bre_pkg::FUNC_ENCODE, 16'h0000, 1'b1);
        repeat (20) send_random_item();
        wait_drain();
    endtask

    initial begin
        model_low = bre_pkg::LOW_RESET;
        model_high = bre_pkg::HIGH_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(35, 0, 0);
        test_random_phase(35, 47, 0);
        test_random_phase(35, 0, 47);
        test_random_phase(35, 25, 25);
        test_output_backpressure();
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/bre_pkg.sv
rtl/core/bre_front.sv
rtl/core/bre_queue.sv
rtl/core/bre_back.sv
rtl/core/binary_range_encoder_core.sv
test/tb_top.sv
